// File: src/scanline_timing_status_unit_core_macros.svh
// Assertion helpers for the scanline timing core.
// Every check is sampled on clk and masked while arst_n is low.
`ifndef SCANLINE_TIMING_STATUS_UNIT_CORE_MACROS_SVH
`define SCANLINE_TIMING_STATUS_UNIT_CORE_MACROS_SVH

// Check that a condition holds at every clock edge.
`define STSU_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a trigger implies a condition in the following cycle.
`define STSU_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// File: src/stsu_pkg.sv
`default_nettype none

package stsu_pkg;

	// Line counter width; holds up to 511 total lines
	localparam int LINE_W = 9;

	// Default timing
	localparam int DRAWN_LINES_DEF       = 192;
	localparam int BLANK_LINES_DEF       = 71;
	localparam int RENDER_LEAD_LINES_DEF = 48;

	// Command codes
	typedef enum logic [1:0] {
		CMD_LINE_START = 2'd0,
		CMD_HBLANK     = 2'd1,
		CMD_READ       = 2'd2,
		CMD_WRITE      = 2'd3
	} cmd_t;

	// Register select codes
	localparam logic REG_STATUS = 1'b0;
	localparam logic REG_VCOUNT = 1'b1;

	// Interrupt bit positions
	localparam int IRQ_VBLANK = 0;
	localparam int IRQ_HBLANK = 1;
	localparam int IRQ_MATCH  = 2;

	// One result word
	typedef struct packed {
		logic [7:0]        rd;
		logic [2:0]        irq0;
		logic [2:0]        irq1;
		logic              dma_vb;
		logic              dma_hb;
		logic              render;
		logic              present;
		logic [LINE_W-1:0] line;
		logic              visible;
	} result_t;

endpackage

`default_nettype wire

// File: src/scanline_timing_status_unit_core.sv
`default_nettype none
`include "scanline_timing_status_unit_core_macros.svh"

// Channel   Handshake             Payload
// --------  --------------------  -----------------------------------------------
// in        in_valid / in_ready   command, cpu_select, reg_select, byte_offset,
//                                 write_data
// out       out_valid / out_ready read_data, irq_first, irq_second,
//                                 dma_vblank_request, dma_hblank_request,
//                                 render_start, frame_present, line_number,
//                                 line_visible
//
// One word per cycle sustained while out_ready holds; an accepted word passes
// the input register, then the result register, before its result is valid.
// All state updates happen in one pass between the two registers.
// Reset leaves the line counter at 1, as after the first line start.
// A stalled result holds the result register; the input register fills once
// more and then in_ready drops.

module scanline_timing_status_unit_core #(
	parameter int DRAWN_LINES       = stsu_pkg::DRAWN_LINES_DEF,
	parameter int BLANK_LINES       = stsu_pkg::BLANK_LINES_DEF,
	parameter int RENDER_LEAD_LINES = stsu_pkg::RENDER_LEAD_LINES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  command,
	input  wire logic                        cpu_select,
	input  wire logic                        reg_select,
	input  wire logic                        byte_offset,
	input  wire logic [7:0]                  write_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [7:0]                       read_data,
	output logic [2:0]                       irq_first,
	output logic [2:0]                       irq_second,
	output logic                             dma_vblank_request,
	output logic                             dma_hblank_request,
	output logic                             render_start,
	output logic                             frame_present,
	output logic [stsu_pkg::LINE_W-1:0]      line_number,
	output logic                             line_visible
);
	import stsu_pkg::*;

	localparam logic [LINE_W-1:0] TOTAL_L  = LINE_W'(DRAWN_LINES + BLANK_LINES);
	localparam logic [LINE_W-1:0] DRAWN_L  = LINE_W'(DRAWN_LINES);
	localparam logic [LINE_W-1:0] LAST_L   = LINE_W'(DRAWN_LINES + BLANK_LINES - 1);
	localparam logic [LINE_W-1:0] RENDER_L =
		LINE_W'(DRAWN_LINES + BLANK_LINES - RENDER_LEAD_LINES);
	localparam logic VBLANK_RST = (DRAWN_LINES == 1);

	// Input stage
	logic              valid_s1;
	cmd_t              cmd_s1;
	logic              cpu_s1;
	logic              reg_s1;
	logic              off_s1;
	logic [7:0]        data_s1;

	// Result stage
	logic              out_valid_q;
	result_t           res_q;

	// State
	logic [LINE_W-1:0] lc_q;
	logic [1:0]        vflag_q;
	logic [1:0]        hflag_q;
	logic [1:0]        mflag_q;
	logic [2:0]        en_q [2];
	logic [LINE_W-1:0] cmp_q [2];

	// Next state and result
	logic [LINE_W-1:0] lc_d;
	logic [1:0]        vflag_d;
	logic [1:0]        hflag_d;
	logic [1:0]        mflag_d;
	logic [2:0]        en_d [2];
	logic [LINE_W-1:0] cmp_d [2];
	logic [2:0]        irq_d [2];
	result_t           res_d;
	logic [LINE_W:0]   lc_inc;
	logic              match_now;
	logic              advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign lc_inc   = {1'b0, lc_q} + (LINE_W+1)'(1);

	// Capture the input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= cmd_t'(command);
			cpu_s1  <= cpu_select;
			reg_s1  <= reg_select;
			off_s1  <= byte_offset;
			data_s1 <= write_data;
		end
	end

	// Work out the effect of one word on state and result
	always_comb begin
		lc_d      = lc_q;
		vflag_d   = vflag_q;
		hflag_d   = hflag_q;
		mflag_d   = mflag_q;
		en_d      = en_q;
		cmp_d     = cmp_q;
		irq_d[0]  = '0;
		irq_d[1]  = '0;
		res_d     = '0;
		match_now = 1'b0;

		unique case (cmd_s1)
			CMD_LINE_START: begin
				// advance and wrap the line counter
				if (lc_inc >= {1'b0, TOTAL_L})
					lc_d = '0;
				else
					lc_d = lc_inc[LINE_W-1:0];
				for (int c = 0; c < 2; c++) begin
					irq_d[c][IRQ_MATCH] = en_q[c][IRQ_MATCH] && !mflag_q[c] &&
						(cmp_q[c] == lc_d);
					mflag_d[c] = (cmp_q[c] == lc_d);
					hflag_d[c] = 1'b0;
					if (lc_d == DRAWN_L) begin
						irq_d[c][IRQ_VBLANK] = en_q[c][IRQ_VBLANK];
						vflag_d[c]           = 1'b1;
					end
					if (lc_d == LAST_L)
						vflag_d[c] = 1'b0;
				end
				res_d.dma_vb  = (lc_d == DRAWN_L);
				res_d.present = (lc_d == DRAWN_L);
				res_d.render  = (lc_d == RENDER_L);
			end
			CMD_HBLANK: begin
				for (int c = 0; c < 2; c++) begin
					hflag_d[c]           = 1'b1;
					irq_d[c][IRQ_HBLANK] = en_q[c][IRQ_HBLANK];
				end
				res_d.dma_hb = (lc_q < DRAWN_L);
			end
			CMD_READ: begin
				if (reg_s1 == REG_STATUS) begin
					if (!off_s1)
						res_d.rd = {cmp_q[cpu_s1][8], 1'b0, en_q[cpu_s1],
							mflag_q[cpu_s1], hflag_q[cpu_s1], vflag_q[cpu_s1]};
					else
						res_d.rd = cmp_q[cpu_s1][7:0];
				end else begin
					if (!off_s1)
						res_d.rd = lc_q[7:0];
					else
						res_d.rd = {7'd0, lc_q[8]};
				end
			end
			CMD_WRITE: begin
				// status write, then recheck the match for that processor
				if (reg_s1 == REG_STATUS) begin
					if (!off_s1) begin
						en_d[cpu_s1]     = data_s1[5:3];
						cmp_d[cpu_s1][8] = data_s1[7];
					end else begin
						cmp_d[cpu_s1][7:0] = data_s1;
					end
					match_now = (cmp_d[cpu_s1] == lc_q);
					irq_d[cpu_s1][IRQ_MATCH] = en_d[cpu_s1][IRQ_MATCH] &&
						!mflag_q[cpu_s1] && match_now;
					mflag_d[cpu_s1] = match_now;
				end
			end
			default: begin
			end
		endcase

		res_d.irq0    = irq_d[0];
		res_d.irq1    = irq_d[1];
		res_d.line    = lc_d;
		res_d.visible = (lc_d < DRAWN_L);
	end

	// Commit state on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q     <= LINE_W'(1);
			vflag_q  <= {2{VBLANK_RST}};
			hflag_q  <= '0;
			mflag_q  <= '0;
			en_q[0]  <= '0;
			en_q[1]  <= '0;
			cmp_q[0] <= '0;
			cmp_q[1] <= '0;
		end else if (advance) begin
			lc_q    <= lc_d;
			vflag_q <= vflag_d;
			hflag_q <= hflag_d;
			mflag_q <= mflag_d;
			en_q    <= en_d;
			cmp_q   <= cmp_d;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_d;
	end

	assign out_valid          = out_valid_q;
	assign read_data          = res_q.rd;
	assign irq_first          = res_q.irq0;
	assign irq_second         = res_q.irq1;
	assign dma_vblank_request = res_q.dma_vb;
	assign dma_hblank_request = res_q.dma_hb;
	assign render_start       = res_q.render;
	assign frame_present      = res_q.present;
	assign line_number        = res_q.line;
	assign line_visible       = res_q.visible;

	// Checks
	`STSU_ASSERT_ALWAYS(a_lc_range, lc_q < TOTAL_L, "line counter beyond total")
	`STSU_ASSERT_NEXT(a_read_quiet, advance && cmd_s1 == CMD_READ,
		res_q.irq0 == 3'd0 && res_q.irq1 == 3'd0 && !res_q.dma_vb && !res_q.dma_hb
		&& !res_q.render && !res_q.present, "read produced a pulse")
	`STSU_ASSERT_ALWAYS(a_present_line, !(out_valid && frame_present) ||
		(dma_vblank_request && line_number == DRAWN_L), "present off vblank line")

endmodule

`default_nettype wire
